// ===== sv/mbpc_pkg.sv =====
// Shared definitions for the memory block pattern checker.
// Field widths, register index codes and the stream control struct.
// No dependencies.
`timescale 1ns / 1ps

package mbpc_pkg;

   localparam int INDEX_BITS = 24;
   localparam int DATA_BITS  = 32;
   localparam int POS_BITS   = 16;
   localparam int COUNT_BITS = 16;

   localparam int CSR_DATA_BITS =
      (DATA_BITS >= INDEX_BITS) ?
         ((DATA_BITS >= POS_BITS) ? DATA_BITS : POS_BITS) :
         ((INDEX_BITS >= POS_BITS) ? INDEX_BITS : POS_BITS);
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NEW_PATTERN     = 3'd0,
      CSR_OLD_PATTERN     = 3'd1,
      CSR_NEW_START       = 3'd2,
      CSR_OLD_START       = 3'd3,
      CSR_NEW_BLOCK_WORDS = 3'd4,
      CSR_OLD_BLOCK_WORDS = 3'd5
   } csr_index_type;

   // Per-beat control of one pattern stream.
   typedef struct packed {
      logic step;     // a word is processed this cycle
      logic restart;  // the word opens a new pass
      logic enable;   // the word belongs to this stream
   } stream_ctl_type;

endpackage

// ===== sv/mbpc_stream.sv =====
// One pattern stream: block position counter and current pattern word.
// Depends on mbpc_pkg.
`timescale 1ns / 1ps

module mbpc_stream (
   input  logic                             clock,
   input  logic                             reset,
   input  mbpc_pkg::stream_ctl_type         ctl,
   input  logic [mbpc_pkg::DATA_BITS-1:0]   load_pattern,
   input  logic [mbpc_pkg::POS_BITS-1:0]    block_words,
   output logic [mbpc_pkg::DATA_BITS-1:0]   pattern
);

   logic [mbpc_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic [mbpc_pkg::DATA_BITS-1:0] pat_ff, pat_in;
   logic [mbpc_pkg::POS_BITS-1:0]  pos_start;
   logic [mbpc_pkg::DATA_BITS-1:0] pat_start;
   logic                           wrap;

   always_comb begin
      pos_start = ctl.restart ? '0 : pos_ff;
      pat_start = ctl.restart ? load_pattern : pat_ff;
      // invert once the block is full, then restart the position
      wrap      = (pos_start >= block_words);
      pattern   = wrap ? ~pat_start : pat_start;
      pos_in    = pos_ff;
      pat_in    = pat_ff;
      if (ctl.step) begin
         if (ctl.enable) begin
            pos_in = (wrap ? '0 : pos_start) + mbpc_pkg::POS_BITS'(1);
            pat_in = pattern;
         end else begin
            pos_in = pos_start;
            pat_in = pat_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         pat_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         pat_ff <= pat_in;
      end
   end

endmodule

// ===== sv/memory_block_pattern_checker.sv =====
// Top level of the memory block pattern checker: register file, input stage,
// two pattern streams, error counter and result register. Uses mbpc_pkg, mbpc_stream.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   word_index, read_data, pass_first
//   rsp      out        rsp_valid/rsp_stall   enables, expected/write data, mismatch, total
//   csr      in         csr_write_enable      csr_index, csr_data
//
// One beat per cycle sustained while rsp_stall is low; each request beat is registered in the
// input stage and then in the result register. The rate is set by the stream and counter update in the work stage.
// Reset clears the registers to their defaults and empties both stages.
// A stalled result holds the work stage; req_stall rises only while that stage is full.
`timescale 1ns / 1ps

module memory_block_pattern_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mbpc_pkg::INDEX_BITS-1:0]      req_word_index,
   input  logic [mbpc_pkg::DATA_BITS-1:0]       req_read_data,
   input  logic                                 req_pass_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_check_enable,
   output logic [mbpc_pkg::DATA_BITS-1:0]       rsp_expected_data,
   output logic                                 rsp_mismatch,
   output logic                                 rsp_write_enable,
   output logic [mbpc_pkg::DATA_BITS-1:0]       rsp_write_data,
   output logic [mbpc_pkg::COUNT_BITS-1:0]      rsp_error_total,
   input  logic                                 csr_write_enable,
   input  logic [mbpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mbpc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // configuration registers
   logic [mbpc_pkg::DATA_BITS-1:0]  new_pattern_ff, old_pattern_ff;
   logic [mbpc_pkg::INDEX_BITS-1:0] new_start_ff, check_start_ff;
   logic [mbpc_pkg::POS_BITS-1:0]   new_block_words_ff, old_block_words_ff;

   // input stage
   logic                            s1_valid_ff;
   logic [mbpc_pkg::INDEX_BITS-1:0] s1_index_ff;
   logic [mbpc_pkg::DATA_BITS-1:0]  s1_data_ff;
   logic                            s1_first_ff;

   // error counter
   logic [mbpc_pkg::COUNT_BITS-1:0] count_ff, count_in, count_base;

   // result register
   logic                            rsp_valid_ff;
   logic                            chk_ff, miss_ff, wr_ff;
   logic [mbpc_pkg::DATA_BITS-1:0]  exp_ff, wdat_ff;
   logic [mbpc_pkg::COUNT_BITS-1:0] total_ff;

   logic                            s1_advance, fire, req_take;
   logic                            chk, wr, miss;
   logic [mbpc_pkg::DATA_BITS-1:0]  exp_word, wr_word, exp_out, wr_out;
   mbpc_pkg::stream_ctl_type        chk_ctl, wr_ctl;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && s1_advance;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   assign chk = (s1_index_ff >= check_start_ff);
   assign wr  = (s1_index_ff >= new_start_ff);

   always_comb begin
      chk_ctl.step    = fire;
      chk_ctl.restart = s1_first_ff;
      chk_ctl.enable  = chk;
      wr_ctl.step     = fire;
      wr_ctl.restart  = s1_first_ff;
      wr_ctl.enable   = wr;
   end

   mbpc_stream u_check_stream (
      .clock        (clock),
      .reset        (reset),
      .ctl          (chk_ctl),
      .load_pattern (old_pattern_ff),
      .block_words  (old_block_words_ff),
      .pattern      (exp_word)
   );

   mbpc_stream u_write_stream (
      .clock        (clock),
      .reset        (reset),
      .ctl          (wr_ctl),
      .load_pattern (new_pattern_ff),
      .block_words  (new_block_words_ff),
      .pattern      (wr_word)
   );

   always_comb begin
      exp_out    = chk ? exp_word : '0;
      wr_out     = wr ? wr_word : '0;
      miss       = chk && (s1_data_ff != exp_word);
      count_base = s1_first_ff ? '0 : count_ff;
      // saturate at the top of the range
      if (miss && (count_base != mbpc_pkg::COUNT_MAX)) begin
         count_in = count_base + mbpc_pkg::COUNT_BITS'(1);
      end else begin
         count_in = count_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_pattern_ff     <= '0;
         old_pattern_ff     <= '0;
         new_start_ff       <= '0;
         check_start_ff     <= '0;
         new_block_words_ff <= mbpc_pkg::POS_BITS'(16);
         old_block_words_ff <= mbpc_pkg::POS_BITS'(16);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mbpc_pkg::CSR_NEW_PATTERN: begin
               new_pattern_ff <= csr_data[mbpc_pkg::DATA_BITS-1:0];
            end
            mbpc_pkg::CSR_OLD_PATTERN: begin
               old_pattern_ff <= csr_data[mbpc_pkg::DATA_BITS-1:0];
            end
            mbpc_pkg::CSR_NEW_START: begin
               new_start_ff <= csr_data[mbpc_pkg::INDEX_BITS-1:0];
            end
            mbpc_pkg::CSR_OLD_START: begin
               check_start_ff <= csr_data[mbpc_pkg::INDEX_BITS-1:0];
            end
            mbpc_pkg::CSR_NEW_BLOCK_WORDS: begin
               new_block_words_ff <= csr_data[mbpc_pkg::POS_BITS-1:0];
            end
            mbpc_pkg::CSR_OLD_BLOCK_WORDS: begin
               old_block_words_ff <= csr_data[mbpc_pkg::POS_BITS-1:0];
            end
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // input stage: load on accept, drain when the beat moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_index_ff <= req_word_index;
         s1_data_ff  <= req_read_data;
         s1_first_ff <= req_pass_first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         chk_ff   <= chk;
         exp_ff   <= exp_out;
         miss_ff  <= miss;
         wr_ff    <= wr;
         wdat_ff  <= wr_out;
         total_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_check_enable  = chk_ff;
   assign rsp_expected_data = exp_ff;
   assign rsp_mismatch      = miss_ff;
   assign rsp_write_enable  = wr_ff;
   assign rsp_write_data    = wdat_ff;
   assign rsp_error_total   = total_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_mismatch || rsp_check_enable))
      else $error("mismatch flagged on an unchecked word");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_check_enable) |-> (rsp_expected_data == '0))
      else $error("expected data not zero outside the check region");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_write_data == '0))
      else $error("write data not zero outside the write region");

   assert property (@(posedge clock) disable iff (reset)
      (fire && !s1_first_ff && miss && (count_ff != mbpc_pkg::COUNT_MAX))
      |=> (count_ff == $past(count_ff) + mbpc_pkg::COUNT_BITS'(1)))
      else $error("error count did not advance on a mismatch");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled while the pipeline has room");
`endif

endmodule
